// ===== sv/solenoid_map_field_interp_defines.svh =====
// assertion macros used by the checker file
`ifndef SOLENOID_MAP_FIELD_INTERP_DEFINES_SVH
`define SOLENOID_MAP_FIELD_INTERP_DEFINES_SVH

// clocked assertion, switched off while reset is low
`define SMFI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SMFI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/smfi_pkg.sv =====
// package: constants and codes of the solenoid field map interpolator
package smfi_pkg;
	localparam int SMFI_TABLE_BINS = 1024;
	localparam int SMFI_STEP_SHIFT = 16;
	localparam int FIELD_W = 24;
	localparam int POS_W = 32;
	localparam logic signed [FIELD_W-1:0] FIELD_MAX = 24'sh7fffff;
	localparam logic signed [FIELD_W-1:0] FIELD_MIN = 24'sh800000;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;
endpackage

// ===== sv/solenoid_map_field_interp.sv =====
// Solenoid axial field map interpolator with paraxial radial field. One
// transaction a cycle is taken while in_stall is low, loads and queries alike;
// a query result leaves through the eight stage chain of table read, slope
// differences, interpolation multiplies, 32 x 45 bit radial
// product in two partial products, rounding and saturation. The five table
// reads a query needs come from four copies of the table, each read at one
// address (lower bin, upper bin, previous and next bin of the nearest one), and
// a load writes all four copies. A load becomes visible to a query accepted
// in the next cycle. When a result is held by out_stall, the whole pipeline
// holds and in_stall is raised. Loads give no result; every query gives one.
module solenoid_map_field_interp
	import smfi_pkg::*;
#(
	parameter int TABLE_BINS = SMFI_TABLE_BINS,
	parameter int STEP_SHIFT = SMFI_STEP_SHIFT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [9:0]                entry_index,
	input  logic signed [FIELD_W-1:0] entry_value,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [FIELD_W-1:0] field_x,
	output logic signed [FIELD_W-1:0] field_y,
	output logic signed [FIELD_W-1:0] field_z,
	output logic                      in_range
);
	localparam int S = STEP_SHIFT;
	localparam int AW = $clog2(TABLE_BINS);
	localparam int DEPTH = 1 << AW;
	localparam int FW = S + 1;
	localparam int TW = S + 2;
	localparam int BZW = S + 27;
	localparam int DW = S + 29;
	localparam int DHW = DW - 25;
	localparam int PW = S + 62;
	localparam int KS = 2 * S + 2;
	localparam int QW = PW - KS;

	// scale down, apply the sign and saturate one radial component
	function automatic logic signed [FIELD_W-1:0] sat_field(
		input logic [PW-1:0] sum,
		input logic          neg
	);
		logic [QW-1:0] q;
		logic signed [FIELD_W-1:0] res;
		q = QW'(sum >> KS);
		if (neg) begin
			res = (q >= QW'(24'h800000)) ? FIELD_MIN : FIELD_W'(-q);
		end else begin
			res = (q > QW'(24'h7fffff)) ? FIELD_MAX : FIELD_W'(q);
		end
		return res;
	endfunction

	logic en;
	logic in_acc;

	// pipeline moves unless the result is held
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign in_acc = in_valid && en;

	// stage 0: bin, fraction and slope weights from |z|
	logic [31:0]   az;
	logic [32:0]   lowb;
	logic [31:0]   frac32;
	logic          rhi;
	logic [33:0]   t34;
	logic          oor0;
	logic [AW-1:0] addr_lo, addr_hi, addr_r, addr_p, addr_n;

	always_comb begin
		az = pos_z[31] ? 32'(-pos_z) : 32'(pos_z);
		lowb = {1'b0, az} >> S;
		oor0 = (lowb + 33'd1) >= 33'(TABLE_BINS);
		frac32 = az & ((32'd1 << S) - 32'd1);
		rhi = |(az & ((32'd1 << S) >> 1));
		t34 = {1'b0, frac32, 1'b0} + (34'd1 << S) - (rhi ? (34'd1 << (S + 1)) : 34'd0);
		addr_lo = AW'(lowb);
		addr_hi = addr_lo + AW'(1);
		addr_r = rhi ? addr_hi : addr_lo;
		addr_p = (addr_r == '0) ? addr_r : addr_r - AW'(1);
		addr_n = (addr_r == AW'(TABLE_BINS - 1)) ? addr_r : addr_r + AW'(1);
	end

	// table copies, read at lower, upper, previous and next bins
	logic                ram_we;
	logic [AW-1:0]       rd_addr [4];
	logic [FIELD_W-1:0]  rd_data [4];

	assign ram_we = in_acc && (func == FUNC_LOAD) && (32'(entry_index) < 32'(TABLE_BINS));
	assign rd_addr[0] = addr_lo;
	assign rd_addr[1] = addr_hi;
	assign rd_addr[2] = addr_p;
	assign rd_addr[3] = addr_n;

	for (genvar k = 0; k < 4; k++) begin : g_copy
		smfi_ram #(
			.WIDTH(FIELD_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we),
			.waddr(AW'(entry_index)),
			.wdata(entry_value),
			.re   (en),
			.raddr(rd_addr[k]),
			.rdata(rd_data[k])
		);
	end

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic oor_s1, oor_s2, oor_s3, oor_s4, oor_s5, oor_s6, oor_s7;
	logic zpos_s1, zpos_s2, zpos_s3, zpos_s4, zpos_s5;
	logic rsel_s1;
	logic [FW-1:0] frac_s1, frac_s2;
	logic [TW-1:0] t_s1, t_s2, wp_s1, wp_s2;
	logic signed [POS_W-1:0] x_s1, y_s1;
	logic [31:0] mx_s2, my_s2, mx_s3, my_s3, mx_s4, my_s4, mx_s5, my_s5;
	logic sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5;
	logic signed [FIELD_W-1:0] f0_s2, f0_s3;
	logic signed [24:0] dz_s2, dp_s2, dn_s2;
	logic signed [BZW-1:0] pz_s3;
	logic signed [DW-2:0] pp_s3, pn_s3;
	logic signed [FIELD_W-1:0] bz_s4, bz_s5, bz_s6, bz_s7;
	logic signed [DW-1:0] d_s4;
	logic [DW-1:0] md_s5;
	logic dneg_s5;
	logic [56:0] px0_s6, py0_s6;
	logic [31+DHW:0] px1_s6, py1_s6;
	logic negx_s6, negy_s6, negx_s7, negy_s7;
	logic [PW-1:0] sumx_s7, sumy_s7;
	logic signed [FIELD_W-1:0] fx_s8, fy_s8, fz_s8;
	logic rng_s8;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && (func == FUNC_QUERY);
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	// combinational helpers between stages
	logic signed [FIELD_W-1:0] tr1;
	logic signed [BZW-1:0] sumz;
	logic signed [DW-1:0] dsum;

	always_comb begin
		tr1 = rsel_s1 ? rd_data[1] : rd_data[0];
		sumz = (BZW'(f0_s3) <<< S) + pz_s3 + BZW'((32'd1 << S) >> 1);
		dsum = DW'(pp_s3) + DW'(pn_s3);
	end

	// payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: query geometry, table reads in flight
			oor_s1 <= oor0;
			zpos_s1 <= !pos_z[31];
			rsel_s1 <= rhi;
			frac_s1 <= FW'(frac32);
			t_s1 <= TW'(t34);
			wp_s1 <= TW'((34'd1 << (S + 1)) - t34);
			x_s1 <= pos_x;
			y_s1 <= pos_y;
			// s2: sample differences and coordinate magnitudes
			oor_s2 <= oor_s1; zpos_s2 <= zpos_s1;
			frac_s2 <= frac_s1; t_s2 <= t_s1; wp_s2 <= wp_s1;
			f0_s2 <= rd_data[0];
			dz_s2 <= {rd_data[1][23], rd_data[1]} - {rd_data[0][23], rd_data[0]};
			dp_s2 <= {tr1[23], tr1} - {rd_data[2][23], rd_data[2]};
			dn_s2 <= {rd_data[3][23], rd_data[3]} - {tr1[23], tr1};
			mx_s2 <= x_s1[31] ? 32'(-x_s1) : 32'(x_s1);
			my_s2 <= y_s1[31] ? 32'(-y_s1) : 32'(y_s1);
			sx_s2 <= x_s1[31]; sy_s2 <= y_s1[31];
			// s3: weight products
			oor_s3 <= oor_s2; zpos_s3 <= zpos_s2;
			mx_s3 <= mx_s2; my_s3 <= my_s2; sx_s3 <= sx_s2; sy_s3 <= sy_s2;
			f0_s3 <= f0_s2;
			pz_s3 <= dz_s2 * $signed({1'b0, frac_s2});
			pp_s3 <= dp_s2 * $signed({1'b0, wp_s2});
			pn_s3 <= dn_s2 * $signed({1'b0, t_s2});
			// s4: axial rounding and slope sum
			oor_s4 <= oor_s3; zpos_s4 <= zpos_s3;
			mx_s4 <= mx_s3; my_s4 <= my_s3; sx_s4 <= sx_s3; sy_s4 <= sy_s3;
			bz_s4 <= FIELD_W'(sumz >>> S);
			d_s4 <= dsum;
			// s5: slope magnitude
			oor_s5 <= oor_s4; zpos_s5 <= zpos_s4;
			mx_s5 <= mx_s4; my_s5 <= my_s4; sx_s5 <= sx_s4; sy_s5 <= sy_s4;
			bz_s5 <= bz_s4;
			dneg_s5 <= d_s4[DW-1];
			md_s5 <= d_s4[DW-1] ? DW'(-d_s4) : DW'(d_s4);
			// s6: radial partial products
			oor_s6 <= oor_s5; bz_s6 <= bz_s5;
			px0_s6 <= mx_s5 * md_s5[24:0];
			px1_s6 <= mx_s5 * md_s5[DW-1:25];
			py0_s6 <= my_s5 * md_s5[24:0];
			py1_s6 <= my_s5 * md_s5[DW-1:25];
			negx_s6 <= ((sx_s5 != dneg_s5) == zpos_s5);
			negy_s6 <= ((sy_s5 != dneg_s5) == zpos_s5);
			// s7: product sum with rounding offset
			oor_s7 <= oor_s6; bz_s7 <= bz_s6;
			negx_s7 <= negx_s6; negy_s7 <= negy_s6;
			sumx_s7 <= PW'(px0_s6) + (PW'(px1_s6) << 25) + (PW'(1) << (KS - 1));
			sumy_s7 <= PW'(py0_s6) + (PW'(py1_s6) << 25) + (PW'(1) << (KS - 1));
			// s8: saturation and out of range zeroing
			fx_s8 <= oor_s7 ? '0 : sat_field(sumx_s7, negx_s7);
			fy_s8 <= oor_s7 ? '0 : sat_field(sumy_s7, negy_s7);
			fz_s8 <= oor_s7 ? '0 : bz_s7;
			rng_s8 <= !oor_s7;
		end
	end

	// result port
	assign out_valid = v_s8;
	assign field_x = fx_s8;
	assign field_y = fy_s8;
	assign field_z = fz_s8;
	assign in_range = rng_s8;
endmodule

// ===== sv/smfi_ram.sv =====
// generic single write port ram with registered read
module smfi_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/smfi_checker.sv =====
// port level checker for the solenoid field map interpolator, with its bind
`include "solenoid_map_field_interp_defines.svh"

module smfi_checker
	import smfi_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [FIELD_W-1:0] field_x,
	input logic signed [FIELD_W-1:0] field_y,
	input logic signed [FIELD_W-1:0] field_z,
	input logic                      in_range
);
	// an out of range transaction carries a zero field
	`SMFI_ASSERT(a_oor_zero, out_valid && !in_range |-> field_x == '0 && field_y == '0 && field_z == '0, "out of range result with non-zero field")
	// input is held back only by a held result
	`SMFI_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held result")
	// a held result stays
	`SMFI_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "held result dropped")
	// a held result keeps its payload
	`SMFI_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(field_x) && $stable(field_y) && $stable(field_z) && $stable(in_range), "held result changed")
endmodule

bind solenoid_map_field_interp smfi_checker u_smfi_checker (.*);

// ===== test/tb_solenoid_map_field_interp.sv =====
// testbench for the solenoid field map interpolator: table loads, field queries, checks
`timescale 1ns / 1ps

module tb_solenoid_map_field_interp;
	import smfi_pkg::*;

	localparam int BINS = SMFI_TABLE_BINS;
	localparam int SHIFT = SMFI_STEP_SHIFT;
	localparam longint SPAN = longint'(BINS - 1) << SHIFT;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic signed [FIELD_W-1:0] fx;
		logic signed [FIELD_W-1:0] fy;
		logic signed [FIELD_W-1:0] fz;
		logic                      ok;
	} field_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic [9:0] entry_index;
	logic signed [FIELD_W-1:0] entry_value;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [FIELD_W-1:0] field_x;
	logic signed [FIELD_W-1:0] field_y;
	logic signed [FIELD_W-1:0] field_z;
	logic in_range;

	logic signed [FIELD_W-1:0] axial_map [BINS];
	field_t pending_fields[$];
	int errors = 0;
	bit gaps_on = 1;
	bit hold_req = 0;
	int hold_cnt = 0;
	int quiet_cycles = 0;

	solenoid_map_field_interp DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .entry_index(entry_index), .entry_value(entry_value),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.field_x(field_x), .field_y(field_y), .field_z(field_z),
		.in_range(in_range)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// radial term: c*sign(z)*d / 2^(2S+2), rounded half away from zero, saturated
	function automatic logic signed [FIELD_W-1:0] radial_term(longint c, longint d, bit zpos);
		longint mc;
		longint md;
		logic [127:0] prod;
		logic [127:0] q;
		bit neg;
		mc = (c < 0) ? -c : c;
		md = (d < 0) ? -d : d;
		neg = (((c < 0) != (d < 0)) == zpos);
		prod = {64'd0, mc} * {64'd0, md};
		q = (prod + (128'd1 << (2 * SHIFT + 1))) >> (2 * SHIFT + 2);
		if (neg)
			return (q >= 128'd8388608) ? FIELD_MIN : -q[FIELD_W-1:0];
		return (q > 128'd8388607) ? FIELD_MAX : q[FIELD_W-1:0];
	endfunction

	// expected field at one point from the current table
	function automatic field_t interp_field(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		field_t res;
		longint az, lowb, frac, r, p, n, t, wp, f0, f1, bz, d;
		bit zpos;
		zpos = (pz >= 0);
		az = zpos ? longint'(pz) : -longint'(pz);
		lowb = az >>> SHIFT;
		frac = az & ((longint'(1) << SHIFT) - 1);
		res = '{fx: '0, fy: '0, fz: '0, ok: 1'b0};
		if (lowb + 1 >= BINS)
			return res;
		f0 = axial_map[lowb];
		f1 = axial_map[lowb + 1];
		bz = f0 * (longint'(1) << SHIFT) + (f1 - f0) * frac + (longint'(1) << (SHIFT - 1));
		bz = bz >>> SHIFT;
		r = (2 * az + (longint'(1) << SHIFT)) >>> (SHIFT + 1);
		p = (r == 0) ? r : r - 1;
		n = (r == BINS - 1) ? r : r + 1;
		t = 2 * az + (longint'(1) << SHIFT) - (r << (SHIFT + 1));
		wp = (longint'(1) << (SHIFT + 1)) - t;
		d = wp * (longint'(axial_map[r]) - longint'(axial_map[p]))
			+ t * (longint'(axial_map[n]) - longint'(axial_map[r]));
		res.fx = radial_term(longint'(px), d, zpos);
		res.fy = radial_term(longint'(py), d, zpos);
		res.fz = bz[FIELD_W-1:0];
		res.ok = 1'b1;
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// one transaction on the input channel, with a random gap ahead of it while gaps are on
	task automatic send(logic f, logic [9:0] idx, logic signed [FIELD_W-1:0] val,
			logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
		int gap;
		gap = gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= f;
		entry_index <= idx;
		entry_value <= val;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (f == FUNC_LOAD)
			axial_map[idx] = val;
		else
			pending_fields = {pending_fields, interp_field(px, py, pz)};
	endtask

	task automatic load(int idx, int val);
		send(FUNC_LOAD, idx[9:0], val[FIELD_W-1:0], $urandom, $urandom, $urandom);
	endtask

	task automatic query(int px, int py, int pz);
		send(FUNC_QUERY, 10'($urandom), 24'($urandom), px, py, pz);
	endtask

	// z mostly inside the table span, sometimes anywhere
	function automatic int random_z();
		int z;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		z = $urandom_range(0, int'(SPAN - 1));
		return $urandom_range(0, 1) ? -z : z;
	endfunction

	function automatic int random_pos();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 2000) - 1000;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// result channel: check and draw the next stall
	always @(posedge clk) begin
		field_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fields.size() == 0) begin
				report("unexpected result", field_z, 0);
			end else begin
				want = pending_fields.pop_front();
				if (field_x !== want.fx) report("field_x", field_x, want.fx);
				if (field_y !== want.fy) report("field_y", field_y, want.fy);
				if (field_z !== want.fz) report("field_z", field_z, want.fz);
				if (in_range !== want.ok) report("in_range", in_range, want.ok);
			end
			hold_cnt = gaps_on ? $urandom_range(0, 14) : 0;
		end
		if (hold_cnt > 0) hold_cnt--;
		out_stall <= hold_req || (hold_cnt > 0);
	end

	// watchdog on cycles with work pending but nothing moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| !(in_valid || pending_fields.size() > 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL solenoid_map_field_interp");
			$finish;
		end
	end

	// every bin written first, extremes at both ends so radial results saturate
	task automatic test_table_fill();
		for (int i = 0; i < BINS; i++) begin
			if (i < 4 || i >= BINS - 4)
				load(i, (i % 2) ? int'(FIELD_MIN) : int'(FIELD_MAX));
			else
				load(i, $urandom);
		end
	endtask

	// field extremes and the edges of the table span
	task automatic test_directed_queries();
		query(0, 0, 0);
		query(1000, -1000, -1);
		query(32'sh7fffffff, 32'sh80000000, 65535);
		query(32'sh80000000, 32'sh7fffffff, -32768);
		query(12345, 67890, 32767);
		query(-5, 5, 98304);
		query(32'sh80000000, 32'sh80000000, int'(SPAN - 1));
		query(32'sh7fffffff, 32'sh7fffffff, -int'(SPAN - 1));
		query(100, 100, int'(SPAN));
		query(100, 100, -int'(SPAN));
		query(1, 1, 32'sh7fffffff);
		query(1, 1, 32'sh80000000);
		query(32'sh7fffffff, -3, int'(SPAN) - 32768);
	endtask

	// each load followed by a query that reads it
	task automatic test_load_then_query();
		load(500, int'(FIELD_MAX));
		query(32'sh7fffffff, 32'sh80000000, 500 << SHIFT);
		load(501, int'(FIELD_MIN));
		query(-77, 77, (500 << SHIFT) + 40000);
		load(600, 0);
		query(9, -9, -(600 << SHIFT));
	endtask

	// receiver holds off for a long stretch while queries keep coming
	task automatic test_backpressure();
		gaps_on = 0;
		fork
			begin
				hold_req = 1'b1;
				repeat (200) @(posedge clk);
				hold_req = 1'b0;
			end
			for (int i = 0; i < 40; i++)
				query(random_pos(), random_pos(), random_z());
		join
		gaps_on = 1;
	endtask

	// random mix of loads and queries, stretches without gaps now and then
	task automatic test_random_mix();
		for (int i = 0; i < 600; i++) begin
			if (i % 150 == 0)
				gaps_on = (i % 300 != 0);
			if ($urandom_range(0, 9) < 3)
				load($urandom_range(0, BINS - 1), $urandom);
			else
				query(random_pos(), random_pos(), random_z());
		end
		gaps_on = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		entry_index = '0;
		entry_value = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed_queries();
		test_load_then_query();
		test_backpressure();
		test_random_mix();
		in_valid <= 1'b0;
		wait (pending_fields.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("PASS solenoid_map_field_interp");
		else
			$display("FAIL solenoid_map_field_interp");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/smfi_pkg.sv
sv/smfi_ram.sv
sv/solenoid_map_field_interp.sv
sv/smfi_checker.sv
test/tb_solenoid_map_field_interp.sv
